@@ sv/hft_pkg.sv @@
// Shared types, constants and byte codes for the HTML to text filter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hft_pkg;

    localparam int TAG_BUF_LEN_DEF    = 6;
    localparam int ENTITY_BUF_LEN_DEF = 4;
    localparam int QUEUE_DEPTH_DEF    = 4;

    localparam int CNT_W = 20;
    localparam logic [CNT_W-1:0] COUNT_MAX = 20'hFFFFF;

    // Configuration port: one register, selected by address bit 2.
    localparam int ADDR_W = 3;
    localparam logic REG_IDX_MAX_TEXT_LEN = 1'b0;
    localparam logic [15:0] MAX_TEXT_LEN_RESET = 16'hFFFF;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    localparam logic [15:0] TAG_BR       = "br";
    localparam logic [23:0] TAG_DIV      = "div";
    localparam logic [31:0] TAG_SPAN     = "span";
    localparam logic [39:0] TAG_STYLE    = "style";
    localparam logic [47:0] TAG_STYLE_NE = "/style";

    localparam logic [15:0] ENT_LT   = "lt";
    localparam logic [15:0] ENT_GT   = "gt";
    localparam logic [23:0] ENT_AMP  = "amp";
    localparam logic [31:0] ENT_QUOT = "quot";
    localparam logic [31:0] ENT_APOS = "apos";

    typedef enum logic [3:0] {
        MODE_TEXT   = 4'b0001,
        MODE_TAG    = 4'b0010,
        MODE_ENTITY = 4'b0100,
        MODE_EAT    = 4'b1000
    } t_mode;

    typedef enum logic [2:0] {
        TK_NONE,
        TK_BREAK,
        TK_SPAN,
        TK_STYLE_ON,
        TK_STYLE_OFF
    } t_tag_kind;

    // One classified source byte as it travels through the queue.
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] lc;
        logic       last;
        logic       blank;
        logic       space;
        logic       nl;
        logic       cr;
        logic       lt;
        logic       gt;
        logic       amp;
        logic       semi;
        logic       hash;
    } t_cls;

    typedef struct packed {
        t_mode            mode;
        logic             in_tag;
        logic             style;
        logic             after_nl;
        logic             after_blank;
        logic             any;
        logic             stop;
        logic             ent_first;
        logic [CNT_W-1:0] ent_cons;
        logic [CNT_W-1:0] text_cnt;
    } t_ctl;

    localparam t_ctl CTL_RESET = '{
        mode:        MODE_TEXT,
        in_tag:      1'b0,
        style:       1'b0,
        after_nl:    1'b0,
        after_blank: 1'b0,
        any:         1'b0,
        stop:        1'b0,
        ent_first:   1'b0,
        ent_cons:    '0,
        text_cnt:    '0
    };

    // Working copy of the state while one byte is carried out.
    typedef struct packed {
        t_ctl       st;
        logic       emit;
        logic [7:0] ch;
        logic       start_tag;
        logic       start_ent;
    } t_work;

endpackage

`default_nettype wire

@@ sv/hft_front.sv @@
// Front end of the HTML to text filter: takes source bytes and classifies them.
// Depends on hft_pkg; feeds hft_queue.
`default_nettype none

module hft_front (
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic [7:0]   i_in_byte,
    input  wire logic         i_in_last,
    input  wire logic         i_q_full,
    output logic              o_push,
    output hft_pkg::t_cls     o_entry
);
    import hft_pkg::*;

    function automatic t_cls classify(input logic [7:0] b, input logic last);
        t_cls c;
        c.raw   = b;
        c.lc    = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_GAP : b;
        c.last  = last;
        c.blank = (b == CH_SPACE) || (b == CH_TAB);
        c.space = (b == CH_SPACE);
        c.nl    = (b == CH_NL);
        c.cr    = (b == CH_CR);
        c.lt    = (b == CH_LT);
        c.gt    = (b == CH_GT);
        c.amp   = (b == CH_AMP);
        c.semi  = (b == CH_SEMI);
        c.hash  = (b == CH_HASH);
        return c;
    endfunction

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign o_entry    = classify(i_in_byte, i_in_last);

endmodule

`default_nettype wire

@@ sv/hft_queue.sv @@
// Short queue of classified bytes between the front and back ends.
// Depends on hft_pkg for the entry type.
`default_nettype none

module hft_queue #(
    parameter int DEPTH = hft_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hft_pkg::t_cls i_entry,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output hft_pkg::t_cls      o_entry
);
    import hft_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCNT_W = $clog2(DEPTH + 1);

    t_cls              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_cnt == QCNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? step_ptr(r_wr) : r_wr;
        n_rd  = i_pop ? step_ptr(r_rd) : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ sv/hft_back.sv @@
// Back end of the HTML to text filter: parse state, tag and entity buffers,
// and the registered result stage. Depends on hft_pkg; fed by hft_queue.
`default_nettype none

module hft_back #(
    parameter int TAG_BUF_LEN    = hft_pkg::TAG_BUF_LEN_DEF,
    parameter int ENTITY_BUF_LEN = hft_pkg::ENTITY_BUF_LEN_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire hft_pkg::t_cls i_q_entry,
    output logic               o_q_pop,
    input  wire logic [15:0]   i_max_text_len,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [7:0]         o_text_byte,
    output logic               o_text_valid,
    output logic               o_doc_end,
    output logic               o_truncated
);
    import hft_pkg::*;

    localparam int TLEN_W = $clog2(TAG_BUF_LEN + 2);
    localparam int TIDX_W = $clog2(TAG_BUF_LEN);
    localparam int ELEN_W = $clog2(ENTITY_BUF_LEN + 2);
    localparam int EIDX_W = $clog2(ENTITY_BUF_LEN);

    logic [7:0]        r_tag [TAG_BUF_LEN];
    logic [7:0]        n_tag [TAG_BUF_LEN];
    logic [7:0]        r_ent [ENTITY_BUF_LEN];
    logic [7:0]        n_ent [ENTITY_BUF_LEN];
    logic [TLEN_W-1:0] r_tlen, n_tlen, n_tlen_fin;
    logic [ELEN_W-1:0] r_elen, n_elen, n_elen_fin;
    t_ctl              r_ctl, n_ctl;
    t_work             w;
    t_tag_kind         kind;
    logic              ent_hit;
    logic [7:0]        ent_char;
    logic              tag_app, ent_app, ent_store;
    logic              take, result;
    t_cls              c;

    logic              r_out_valid;
    logic [7:0]        r_text_byte;
    logic              r_text_valid, r_doc_end, r_truncated;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
        return (a == COUNT_MAX) ? a : a + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic t_work finish_tag(input t_work wi, input t_tag_kind k);
        t_work wo;
        logic  e;
        wo = wi;
        e  = 1'b0;
        wo.st.mode = MODE_TEXT;
        case (k)
            TK_BREAK: begin
                if (!wo.st.after_nl) begin
                    wo.ch = CH_NL;
                    e = 1'b1;
                    wo.st.after_nl = 1'b1;
                end
            end
            TK_SPAN: begin
                if (!wo.st.after_blank) begin
                    wo.ch = CH_SPACE;
                    e = 1'b1;
                    wo.st.after_blank = 1'b1;
                end
            end
            TK_STYLE_ON:  wo.st.style = 1'b1;
            TK_STYLE_OFF: wo.st.style = 1'b0;
            default: ;
        endcase
        if (e) begin
            wo.st.text_cnt = sat_inc(wo.st.text_cnt);
            wo.st.any = 1'b1;
        end
        wo.emit = e;
        return wo;
    endfunction

    function automatic t_work finish_entity(input t_work wi, input logic hit,
                                            input logic [7:0] ech);
        t_work wo;
        wo = wi;
        wo.st.mode = MODE_TEXT;
        wo.st.text_cnt = sat_add(wo.st.text_cnt, wo.st.ent_cons);
        if (hit) begin
            wo.ch = ech;
            wo.st.any = 1'b1;
        end
        wo.emit = hit;
        return wo;
    endfunction

    // A byte handled as text; on an emitted character sets emit, never clears it.
    function automatic t_work plain_byte(input t_work wi, input t_cls b,
                                         input logic [15:0] lim);
        t_work wo;
        wo = wi;
        if (wo.st.stop) begin
            wo = wi;
        end else if (wo.st.text_cnt > {4'b0, lim}) begin
            wo.st.stop = 1'b1;
        end else if (b.lt) begin
            wo.st.in_tag = 1'b1;
            wo.st.mode = MODE_TAG;
            wo.start_tag = 1'b1;
        end else if (b.gt) begin
            wo.st.in_tag = 1'b0;
        end else if (b.amp) begin
            wo.st.mode = MODE_ENTITY;
            wo.start_ent = 1'b1;
            wo.st.ent_first = 1'b1;
            wo.st.ent_cons = CNT_W'(1);
        end else if (wo.st.in_tag || (!wo.st.any && b.space) || wo.st.style ||
                     (wo.st.after_nl && (b.cr || b.nl)) ||
                     (wo.st.after_blank && b.space)) begin
            wo = wi;
        end else begin
            wo.st.after_nl = b.nl;
            wo.st.after_blank = b.blank;
            wo.st.text_cnt = sat_inc(wo.st.text_cnt);
            wo.st.any = 1'b1;
            wo.ch = b.raw;
            wo.emit = 1'b1;
            if (b.nl) begin
                wo.st.mode = MODE_EAT;
            end
        end
        return wo;
    endfunction

    assign c       = i_q_entry;
    assign take    = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop = take;

    // Buffer updates come first: a final byte flushes the name it completes.
    always_comb begin
        n_tag  = r_tag;
        n_tlen = r_tlen;
        n_ent  = r_ent;
        n_elen = r_elen;
        tag_app   = !r_ctl.stop && (r_ctl.mode == MODE_TAG) && !(c.blank || c.gt);
        ent_app   = !r_ctl.stop && (r_ctl.mode == MODE_ENTITY) && !c.semi;
        ent_store = ent_app && !(r_ctl.ent_first && c.hash);
        if (tag_app) begin
            if (r_tlen < TLEN_W'(TAG_BUF_LEN)) begin
                n_tag[r_tlen[TIDX_W-1:0]] = c.lc;
            end
            if (r_tlen < TLEN_W'(TAG_BUF_LEN + 1)) begin
                n_tlen = r_tlen + TLEN_W'(1);
            end
        end
        if (ent_store) begin
            if (r_elen < ELEN_W'(ENTITY_BUF_LEN)) begin
                n_ent[r_elen[EIDX_W-1:0]] = c.lc;
            end
            if (r_elen < ELEN_W'(ENTITY_BUF_LEN + 1)) begin
                n_elen = r_elen + ELEN_W'(1);
            end
        end
    end

    always_comb begin
        kind = TK_NONE;
        if ((n_tlen == TLEN_W'(2) && {n_tag[0], n_tag[1]} == TAG_BR) ||
            (n_tlen == TLEN_W'(3) && {n_tag[0], n_tag[1], n_tag[2]} == TAG_DIV)) begin
            kind = TK_BREAK;
        end else if (n_tlen == TLEN_W'(4) &&
                     {n_tag[0], n_tag[1], n_tag[2], n_tag[3]} == TAG_SPAN) begin
            kind = TK_SPAN;
        end else if (n_tlen == TLEN_W'(5) &&
                     {n_tag[0], n_tag[1], n_tag[2], n_tag[3], n_tag[4]} == TAG_STYLE) begin
            kind = TK_STYLE_ON;
        end else if (n_tlen == TLEN_W'(6) &&
                     {n_tag[0], n_tag[1], n_tag[2], n_tag[3], n_tag[4], n_tag[5]}
                     == TAG_STYLE_NE) begin
            kind = TK_STYLE_OFF;
        end
    end

    always_comb begin
        ent_hit  = 1'b1;
        ent_char = '0;
        if (n_elen == ELEN_W'(2) && {n_ent[0], n_ent[1]} == ENT_LT) begin
            ent_char = CH_LT;
        end else if (n_elen == ELEN_W'(2) && {n_ent[0], n_ent[1]} == ENT_GT) begin
            ent_char = CH_GT;
        end else if (n_elen == ELEN_W'(3) && {n_ent[0], n_ent[1], n_ent[2]} == ENT_AMP) begin
            ent_char = CH_AMP;
        end else if (n_elen == ELEN_W'(4) &&
                     {n_ent[0], n_ent[1], n_ent[2], n_ent[3]} == ENT_QUOT) begin
            ent_char = CH_QUOT;
        end else if (n_elen == ELEN_W'(4) &&
                     {n_ent[0], n_ent[1], n_ent[2], n_ent[3]} == ENT_APOS) begin
            ent_char = CH_APOS;
        end else begin
            ent_hit = 1'b0;
        end
    end

    always_comb begin
        w = '{st: r_ctl, emit: 1'b0, ch: '0, start_tag: 1'b0, start_ent: 1'b0};
        if (!r_ctl.stop) begin
            unique case (r_ctl.mode)
                MODE_TAG: begin
                    if (c.blank || c.gt) begin
                        w = finish_tag(w, kind);
                        w = plain_byte(w, c, i_max_text_len);
                    end
                end
                MODE_ENTITY: begin
                    if (c.semi) begin
                        w = finish_entity(w, ent_hit, ent_char);
                    end else begin
                        w.st.ent_first = 1'b0;
                        w.st.ent_cons = sat_inc(w.st.ent_cons);
                    end
                end
                MODE_EAT: begin
                    if (!c.blank) begin
                        w.st.mode = MODE_TEXT;
                        w = plain_byte(w, c, i_max_text_len);
                    end
                end
                MODE_TEXT: begin
                    w = plain_byte(w, c, i_max_text_len);
                end
                default: ;
            endcase
            // A tag or entity opened by this very byte is still empty.
            if (c.last && !w.emit) begin
                if (w.st.mode == MODE_TAG) begin
                    w = finish_tag(w, w.start_tag ? TK_NONE : kind);
                end else if (w.st.mode == MODE_ENTITY) begin
                    w = finish_entity(w, ent_hit && !w.start_ent, ent_char);
                end
            end
        end
        result = w.emit || c.last;
        n_ctl      = c.last ? CTL_RESET : w.st;
        n_tlen_fin = (c.last || w.start_tag) ? '0 : n_tlen;
        n_elen_fin = (c.last || w.start_ent) ? '0 : n_elen;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tag <= n_tag;
            r_ent <= n_ent;
        end
        if (take && result) begin
            r_text_byte  <= w.emit ? w.ch : 8'h00;
            r_text_valid <= w.emit;
            r_doc_end    <= c.last;
            r_truncated  <= w.st.stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= CTL_RESET;
            r_tlen      <= '0;
            r_elen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_ctl  <= n_ctl;
                r_tlen <= n_tlen_fin;
                r_elen <= n_elen_fin;
            end
            if (take && result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_text_byte  = r_text_byte;
    assign o_text_valid = r_text_valid;
    assign o_doc_end    = r_doc_end;
    assign o_truncated  = r_truncated;

endmodule

`default_nettype wire

@@ sv/html_to_text_filter.sv @@
// HTML to text filter, top level: one byte per cycle unless stalled; output is registered.
// A byte accepted is stored in the queue, then parsed and registered in the result stage.
// Throughput: one byte per cycle unless the output stalls, set by the back-end parse step.
// The queue between front and back, four entries by default, absorbs output stalls.
// Reset is synchronous, active low: parse state, queue and output clear, limit becomes 65535.
// Depends on hft_pkg, hft_front, hft_queue and hft_back.
`default_nettype none

module html_to_text_filter #(
    parameter int TAG_BUF_LEN    = hft_pkg::TAG_BUF_LEN_DEF,
    parameter int ENTITY_BUF_LEN = hft_pkg::ENTITY_BUF_LEN_DEF,
    parameter int QUEUE_DEPTH    = hft_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [7:0]                 i_in_byte,
    input  wire logic                       i_in_last,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [7:0]                      o_text_byte,
    output logic                            o_text_valid,
    output logic                            o_doc_end,
    output logic                            o_truncated,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hft_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import hft_pkg::*;

    logic [15:0] r_max_text_len;
    logic        push, q_full, q_valid, q_pop;
    t_cls        f_entry, q_entry;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_MAX_TEXT_LEN) ? {16'h0000, r_max_text_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_text_len <= MAX_TEXT_LEN_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_IDX_MAX_TEXT_LEN) begin
            r_max_text_len <= pwdata[15:0];
        end
    end

    hft_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (f_entry)
    );

    hft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    hft_back #(
        .TAG_BUF_LEN    (TAG_BUF_LEN),
        .ENTITY_BUF_LEN (ENTITY_BUF_LEN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_entry      (q_entry),
        .o_q_pop        (q_pop),
        .i_max_text_len (r_max_text_len),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_text_byte    (o_text_byte),
        .o_text_valid   (o_text_valid),
        .o_doc_end      (o_doc_end),
        .o_truncated    (o_truncated)
    );

endmodule

`default_nettype wire
